[rtl/sst_pkg.sv]
// Shared types, sizes and codes for the suspend timeout table.
package sst_pkg;

  localparam int CAPACITY    = 1024;
  localparam int MAX_RELEASE = 16;

  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int REL_W    = $clog2(MAX_RELEASE + 1);
  localparam int ID_W     = 23;
  localparam int TIME_W   = 32;
  localparam int TO_W     = 16;
  localparam int HELD_W   = 11;
  localparam int ENTRY_W  = ID_W + TIME_W;
  localparam logic [TO_W-1:0] TIMEOUT_RESET = TO_W'(5);
  localparam logic [1:0]      REG_TIMEOUT   = 2'd0;

  typedef enum logic [1:0] {
    ACT_ADD  = 2'd0,
    ACT_DEL  = 2'd1,
    ACT_TICK = 2'd2,
    ACT_RSVD = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_RELEASED  = 3'd0,
    ST_ADDED     = 3'd1,
    ST_DELETED   = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_FULL      = 3'd4,
    ST_NONE      = 3'd5
  } status_t;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] start;
  } entry_t;

  function automatic logic [HELD_W-1:0] to_held(input logic [CNT_W-1:0] cnt);
    logic [CNT_W+HELD_W-1:0] wide;
    wide = (CNT_W + HELD_W)'(cnt);
    return wide[HELD_W-1:0];
  endfunction

endpackage

[rtl/sst_req_if.sv]
// Request channel: action, process id and current time.
interface sst_req_if import sst_pkg::*; ();
  logic              valid;
  logic              ready;
  action_t           action;
  logic [ID_W-1:0]   proc_id;
  logic [TIME_W-1:0] now_seconds;

  modport source (output valid, action, proc_id, now_seconds, input ready);
  modport sink   (input valid, action, proc_id, now_seconds, output ready);
endinterface

[rtl/sst_rsp_if.sv]
// Result channel: status, id concerned, table occupancy and last flag.
interface sst_rsp_if import sst_pkg::*; ();
  logic              valid;
  logic              ready;
  status_t           status;
  logic [ID_W-1:0]   released_id;
  logic [HELD_W-1:0] entries_held;
  logic              last;

  modport source (output valid, status, released_id, entries_held, last, input ready);
  modport sink   (input valid, status, released_id, entries_held, last, output ready);
endinterface

[rtl/suspend_timeout_table.sv]
// Suspend timeout table: ordered id/start-time table with add, delete and tick.
//
// Usage: the req channel carries one item per beat (action, proc_id,
// now_seconds); the rsp channel returns the result beats, the final one of
// each item flagged by last. timeout_seconds sits at APB byte address 0.
// Add: one result beat, set in the finish state once the output is free.
// Delete and tick walk the table through one RAM read port, for each stored
// entry a read, then an evaluate that writes kept entries back compacted;
// a tick releases up to MAX_RELEASE entries, each release beat held until
// the next is found and the last one sent as the item's final beat.
// One item is worked at a time; req.ready is high only between items.
// Reserved actions are taken and produce nothing.
// Reset empties the table at once (the occupancy count clears, the RAM is
// not swept) and sets timeout_seconds to 5.
// A stalled receiver holds the result register; a tick walk pauses on a
// release until the earlier held release beat can move out.
module suspend_timeout_table import sst_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  sst_req_if.sink     req,
  sst_rsp_if.source   rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  typedef enum logic [1:0] {S_IDLE, S_RD, S_EV, S_FIN} state_t;

  state_t            state;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  idx;
  logic [CNT_W-1:0]  wr_ptr;
  logic [CNT_W-1:0]  left;
  logic [REL_W-1:0]  rel;
  logic              found;
  logic              full;
  logic [TO_W-1:0]   timeout;
  action_t           op;
  logic [ID_W-1:0]   pid;
  logic [TIME_W-1:0] now_r;
  logic              pend_valid;
  logic [ID_W-1:0]   pend_id;
  logic [HELD_W-1:0] pend_held;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  entry_t            ram_wdata;
  logic              ram_re;
  logic [ENTRY_W-1:0] ram_rdata;
  entry_t            rd_entry;
  logic [TIME_W-1:0] age;
  logic              remove;
  logic              stall;
  logic              out_free;
  logic              req_acc;

  sst_ram #(.WIDTH(ENTRY_W), .DEPTH(CAPACITY)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (idx[ADDR_W-1:0]),
    .rdata (ram_rdata)
  );

  assign pready    = 1'b1;
  assign prdata    = 32'(timeout);
  assign req.ready = (state == S_IDLE);
  assign req_acc   = req.valid && req.ready;
  assign out_free  = !rsp.valid || rsp.ready;
  assign rd_entry  = entry_t'(ram_rdata);
  assign age       = now_r - rd_entry.start;

  always_comb begin
    remove = 1'b0;
    if (op == ACT_DEL) begin
      remove = !found && (rd_entry.id == pid);
    end else begin
      remove = (rel != REL_W'(MAX_RELEASE)) && (age >= TIME_W'(timeout));
    end
    stall = (op == ACT_TICK) && remove && pend_valid && !out_free;

    ram_re    = (state == S_RD) && (idx != count);
    ram_we    = 1'b0;
    ram_waddr = wr_ptr[ADDR_W-1:0];
    ram_wdata = rd_entry;
    if (state == S_IDLE) begin
      ram_we    = req_acc && (req.action == ACT_ADD) && (count < CNT_W'(CAPACITY));
      ram_waddr = count[ADDR_W-1:0];
      ram_wdata = '{id: req.proc_id, start: req.now_seconds};
    end else if (state == S_EV) begin
      ram_we = !stall && !remove;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      timeout    <= TIMEOUT_RESET;
      rsp.valid  <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == REG_TIMEOUT) begin
        timeout <= pwdata[TO_W-1:0];
      end
      if (rsp.valid && rsp.ready) begin
        rsp.valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (req_acc) begin
            op         <= req.action;
            pid        <= req.proc_id;
            now_r      <= req.now_seconds;
            idx        <= '0;
            wr_ptr     <= '0;
            left       <= count;
            rel        <= '0;
            found      <= 1'b0;
            pend_valid <= 1'b0;
            unique case (req.action)
              ACT_ADD: begin
                full  <= (count >= CNT_W'(CAPACITY));
                if (count < CNT_W'(CAPACITY)) begin
                  count <= count + 1'b1;
                end
                state <= S_FIN;
              end
              ACT_DEL, ACT_TICK: state <= S_RD;
              default: state <= S_IDLE;
            endcase
          end
        end
        S_RD: begin
          state <= (idx == count) ? S_FIN : S_EV;
        end
        S_EV: begin
          if (!stall) begin
            if (!remove) begin
              wr_ptr <= wr_ptr + 1'b1;
            end else if (op == ACT_DEL) begin
              found <= 1'b1;
            end else begin
              rel        <= rel + 1'b1;
              left       <= left - 1'b1;
              pend_valid <= 1'b1;
              pend_id    <= rd_entry.id;
              pend_held  <= to_held(left - 1'b1);
              if (pend_valid) begin
                rsp.valid        <= 1'b1;
                rsp.status       <= ST_RELEASED;
                rsp.released_id  <= pend_id;
                rsp.entries_held <= pend_held;
                rsp.last         <= 1'b0;
              end
            end
            idx   <= idx + 1'b1;
            state <= S_RD;
          end
        end
        S_FIN: begin
          if (out_free) begin
            rsp.valid <= 1'b1;
            rsp.last  <= 1'b1;
            state     <= S_IDLE;
            priority if (op == ACT_ADD) begin
              rsp.status       <= full ? ST_FULL : ST_ADDED;
              rsp.released_id  <= full ? '0 : pid;
              rsp.entries_held <= to_held(count);
            end else if (op == ACT_DEL) begin
              count            <= wr_ptr;
              rsp.status       <= found ? ST_DELETED : ST_NOT_FOUND;
              rsp.released_id  <= found ? pid : '0;
              rsp.entries_held <= to_held(wr_ptr);
            end else begin
              count            <= wr_ptr;
              pend_valid       <= 1'b0;
              rsp.status       <= pend_valid ? ST_RELEASED : ST_NONE;
              rsp.released_id  <= pend_valid ? pend_id : '0;
              rsp.entries_held <= pend_valid ? pend_held : to_held(wr_ptr);
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("occupancy beyond capacity");

  a_wr_behind_rd: assert property (@(posedge clk) disable iff (rst)
    (state == S_EV) |-> (wr_ptr <= idx) && (idx < count))
    else $error("write pointer overtook read index");

  a_rel_bound: assert property (@(posedge clk) disable iff (rst)
    rel <= REL_W'(MAX_RELEASE))
    else $error("release count beyond limit");

  a_no_out_overrun: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && !rsp.ready) |=> rsp.valid && $stable(rsp.released_id))
    else $error("result overwritten while stalled");

endmodule

[rtl/sst_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read.
module sst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
